// ----- design/jdct_pkg.sv -----
// Package for the Julian day to calendar time converter.
// Holds widths, types, reciprocal constants and calendar tables; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jdct_pkg;

    // Port and internal widths
    localparam int JDAY_W     = 30;
    localparam int MS_W       = 32;
    localparam int DAY_W      = 31;   // day number after the day carry
    localparam int TOD_W      = 27;   // milliseconds within one day
    localparam int CARRY_W    = 6;    // whole days in a 32-bit ms count (up to 49)
    localparam int SECS_W     = 17;   // seconds within one day
    localparam int MSEC_W     = 10;   // milliseconds within one second
    localparam int SIH_W      = 12;   // seconds within one hour
    localparam int SOM_W      = 6;    // seconds within one minute
    localparam int MONTH_W    = 4;
    localparam int DOM_W      = 5;
    localparam int YEAR_W     = 23;
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int SMS_W      = 16;

    typedef logic [DAY_W-1:0]  day_num_t;
    typedef logic [TOD_W-1:0]  tod_ms_t;
    typedef logic [SECS_W-1:0] secs_t;

    // Start of result strobe relative to the accepting edge
    localparam int PIPE_LATENCY = 9;

    // Day carry: ms / 86400000 = (ms >> 10) / 84375
    localparam logic [TOD_W-1:0] MS_PER_DAY   = 27'd86400000;
    localparam int               DAY_PRESHIFT = 10;
    localparam logic [16:0]      DAY_DIV      = 17'd84375;
    localparam int               DAY_RECIP_SH = 39;
    localparam int               DAY_RECIP_W  = 23;
    localparam logic [DAY_RECIP_W-1:0] DAY_RECIP =
        23'(((64'd1 << DAY_RECIP_SH) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV));
    localparam int DAY_PROD_W = (MS_W - DAY_PRESHIFT) + DAY_RECIP_W;

    // Seconds of day: tod / 1000 = (tod >> 3) / 125
    localparam logic [MSEC_W-1:0] MS_PER_SEC   = 10'd1000;
    localparam int                SEC_PRESHIFT = 3;
    localparam logic [6:0]        SEC_DIV      = 7'd125;
    localparam int                SEC_RECIP_SH = 31;
    localparam int                SEC_RECIP_W  = 25;
    localparam logic [SEC_RECIP_W-1:0] SEC_RECIP =
        25'(((64'd1 << SEC_RECIP_SH) + 64'(SEC_DIV) - 64'd1) / 64'(SEC_DIV));
    localparam int SEC_PROD_W = (TOD_W - SEC_PRESHIFT) + SEC_RECIP_W;

    // Hour: secs / 3600 = (secs >> 4) / 225
    localparam logic [SIH_W-1:0] SECS_PER_HOUR = 12'd3600;
    localparam int               HR_PRESHIFT   = 4;
    localparam logic [7:0]       HR_DIV        = 8'd225;
    localparam int               HR_RECIP_SH   = 21;
    localparam int               HR_RECIP_W    = 14;
    localparam logic [HR_RECIP_W-1:0] HR_RECIP =
        14'(((64'd1 << HR_RECIP_SH) + 64'(HR_DIV) - 64'd1) / 64'(HR_DIV));
    localparam int HR_PROD_W = (SECS_W - HR_PRESHIFT) + HR_RECIP_W;

    // Minute: sih / 60 = (sih >> 2) / 15
    localparam logic [SOM_W-1:0] SECS_PER_MIN = 6'd60;
    localparam int               MIN_PRESHIFT = 2;
    localparam logic [3:0]       MIN_DIV      = 4'd15;
    localparam int               MIN_RECIP_SH = 14;
    localparam int               MIN_RECIP_W  = 11;
    localparam logic [MIN_RECIP_W-1:0] MIN_RECIP =
        11'(((64'd1 << MIN_RECIP_SH) + 64'(MIN_DIV) - 64'd1) / 64'(MIN_DIV));
    localparam int MIN_PROD_W = (SIH_W - MIN_PRESHIFT) + MIN_RECIP_W;

    // Gregorian century correction: alpha = (4*(d - 1867216) - 1) / 146097
    localparam day_num_t     GREG_START    = 31'd2299161;
    localparam logic [32:0]  ALPHA_OFS     = 33'd7468865;   // 4*1867216 + 1
    localparam int           ALPHA_NUM_W   = 32;
    localparam logic [17:0]  ALPHA_DIV     = 18'd146097;
    localparam int           ALPHA_SH      = 50;
    localparam int           ALPHA_RECIP_W = 33;
    localparam logic [ALPHA_RECIP_W-1:0] ALPHA_RECIP =
        33'(((64'd1 << ALPHA_SH) + 64'(ALPHA_DIV) - 64'd1) / 64'(ALPHA_DIV));
    localparam int ALPHA_PROD_W = ALPHA_NUM_W + ALPHA_RECIP_W;
    localparam int ALPHA_W      = 15;

    // Year count: c = (20*b - 2442) / 7305 = (4*(b - 123) + 3) / 1461
    localparam day_num_t     B_OFS        = 31'd1524;
    localparam day_num_t     B_BACK       = 31'd123;
    localparam logic [10:0]  CYCLE_DAYS   = 11'd1461;
    localparam int           Q1_SH        = 42;
    localparam int           Q1_RECIP_W   = 32;
    localparam logic [Q1_RECIP_W-1:0] Q1_RECIP =
        32'(((64'd1 << Q1_SH) + 64'(CYCLE_DAYS) - 64'd1) / 64'(CYCLE_DAYS));
    localparam int Q1_PROD_W  = DAY_W + Q1_RECIP_W;
    localparam int Q1_W       = 21;
    localparam int R1_W       = 11;
    localparam int C_W        = 23;
    localparam int CD_W       = 32;
    localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

    // Month index and day of month
    localparam int REM_W = 9;
    localparam int E_W   = 4;
    localparam int E_MAX = 15;
    // Smallest day remainder giving month index k: floor(30.6001*k) + 1
    localparam logic [REM_W-1:0] E_THRESH [1:E_MAX] = '{
        9'd31,  9'd62,  9'd92,  9'd123, 9'd154, 9'd184, 9'd215, 9'd245,
        9'd276, 9'd307, 9'd337, 9'd368, 9'd398, 9'd429, 9'd460
    };
    // floor(30.6001*e)
    localparam logic [REM_W-1:0] E_DAYS [16] = '{
        9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
        9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
    };
    localparam logic [REM_W-1:0] REM_MIN = 9'd123;
    localparam logic [REM_W-1:0] REM_MAX = 9'd488;

    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [MONTH_W-1:0] FEBRUARY        = 4'd2;
    localparam int                 YR_CALC_W       = 25;
    localparam logic [12:0]        YEAR_EPOCH      = 13'd4715;

endpackage

`default_nettype wire

// ----- design/jdct_day_split.sv -----
// Day carry front end: splits whole days out of the millisecond count.
// Depends on jdct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jdct_day_split
    import jdct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [JDAY_W-1:0] julian_day,
    input  logic [MS_W-1:0]   millis_of_day,
    output logic              out_valid,
    output day_num_t          day_num,
    output tod_ms_t           tod_ms
);

    logic [1:0]            vld_reg;
    logic [DAY_PROD_W-1:0] day_prod;
    logic [JDAY_W-1:0]     s1_jday_reg;
    logic [MS_W-1:0]       s1_ms_reg;
    logic [CARRY_W-1:0]    s1_carry_reg;
    logic [CARRY_W-1:0]    s1_carry_next;
    logic [MS_W-1:0]       carry_ms;
    day_num_t              s2_day_reg;
    day_num_t              s2_day_next;
    tod_ms_t               s2_tod_reg;
    tod_ms_t               s2_tod_next;

    // Whole days by reciprocal multiply, exact for every 22-bit operand
    assign day_prod = DAY_PROD_W'(millis_of_day[MS_W-1:DAY_PRESHIFT])
                    * DAY_PROD_W'(DAY_RECIP);
    assign s1_carry_next = day_prod[DAY_RECIP_SH +: CARRY_W];

    assign carry_ms    = MS_W'(s1_carry_reg) * MS_W'(MS_PER_DAY);
    assign s2_tod_next = TOD_W'(s1_ms_reg - carry_ms);
    assign s2_day_next = DAY_W'(s1_jday_reg) + DAY_W'(s1_carry_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s1_jday_reg  <= julian_day;
            s1_ms_reg    <= millis_of_day;
            s1_carry_reg <= s1_carry_next;
        end
        if (vld_reg[0])
        begin
            s2_day_reg <= s2_day_next;
            s2_tod_reg <= s2_tod_next;
        end
    end

    assign out_valid = vld_reg[1];
    assign day_num   = s2_day_reg;
    assign tod_ms    = s2_tod_reg;

    ap_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tod_ms < MS_PER_DAY))
        else $error("day split left a full day in the time of day");

endmodule

`default_nettype wire

// ----- design/jdct_time.sv -----
// Time-of-day pipeline: hour, minute and milliseconds within the minute.
// Depends on jdct_pkg; fixed latency of seven register stages.
`timescale 1ns / 1ps
`default_nettype none

module jdct_time
    import jdct_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  tod_ms_t             tod_ms,
    output logic [HOUR_W-1:0]   hour,
    output logic [MINUTE_W-1:0] minute,
    output logic [SMS_W-1:0]    second_millis
);

    logic [5:0]            vld_reg;

    logic [SEC_PROD_W-1:0] secs_prod;
    tod_ms_t               t1_tod_reg;
    secs_t                 t1_secs_reg;
    secs_t                 t1_secs_next;

    logic [TOD_W-1:0]      sec_ms;
    logic [HR_PROD_W-1:0]  hr_prod;
    logic [MSEC_W-1:0]     t2_msec_reg;
    logic [MSEC_W-1:0]     t2_msec_next;
    secs_t                 t2_secs_reg;
    logic [HOUR_W-1:0]     t2_hour_reg;
    logic [HOUR_W-1:0]     t2_hour_next;

    logic [SECS_W-1:0]     hour_secs;
    logic [MSEC_W-1:0]     t3_msec_reg;
    logic [HOUR_W-1:0]     t3_hour_reg;
    logic [SIH_W-1:0]      t3_sih_reg;
    logic [SIH_W-1:0]      t3_sih_next;

    logic [MIN_PROD_W-1:0] min_prod;
    logic [MSEC_W-1:0]     t4_msec_reg;
    logic [HOUR_W-1:0]     t4_hour_reg;
    logic [SIH_W-1:0]      t4_sih_reg;
    logic [MINUTE_W-1:0]   t4_min_reg;
    logic [MINUTE_W-1:0]   t4_min_next;

    logic [SIH_W-1:0]      min_secs;
    logic [MSEC_W-1:0]     t5_msec_reg;
    logic [HOUR_W-1:0]     t5_hour_reg;
    logic [MINUTE_W-1:0]   t5_min_reg;
    logic [SOM_W-1:0]      t5_som_reg;
    logic [SOM_W-1:0]      t5_som_next;

    logic [HOUR_W-1:0]     t6_hour_reg;
    logic [MINUTE_W-1:0]   t6_min_reg;
    logic [SMS_W-1:0]      t6_sms_reg;
    logic [SMS_W-1:0]      t6_sms_next;

    logic [HOUR_W-1:0]     hour_reg;
    logic [MINUTE_W-1:0]   minute_reg;
    logic [SMS_W-1:0]      sms_reg;

    assign secs_prod    = SEC_PROD_W'(tod_ms[TOD_W-1:SEC_PRESHIFT]) * SEC_PROD_W'(SEC_RECIP);
    assign t1_secs_next = secs_prod[SEC_RECIP_SH +: SECS_W];

    assign sec_ms       = TOD_W'(t1_secs_reg) * TOD_W'(MS_PER_SEC);
    assign t2_msec_next = MSEC_W'(t1_tod_reg - sec_ms);
    assign hr_prod      = HR_PROD_W'(t1_secs_reg[SECS_W-1:HR_PRESHIFT]) * HR_PROD_W'(HR_RECIP);
    assign t2_hour_next = hr_prod[HR_RECIP_SH +: HOUR_W];

    assign hour_secs    = SECS_W'(t2_hour_reg) * SECS_W'(SECS_PER_HOUR);
    assign t3_sih_next  = SIH_W'(t2_secs_reg - hour_secs);

    assign min_prod     = MIN_PROD_W'(t3_sih_reg[SIH_W-1:MIN_PRESHIFT]) * MIN_PROD_W'(MIN_RECIP);
    assign t4_min_next  = min_prod[MIN_RECIP_SH +: MINUTE_W];

    assign min_secs     = SIH_W'(t4_min_reg) * SIH_W'(SECS_PER_MIN);
    assign t5_som_next  = SOM_W'(t4_sih_reg - min_secs);

    assign t6_sms_next  = SMS_W'(SMS_W'(t5_som_reg) * SMS_W'(MS_PER_SEC) + SMS_W'(t5_msec_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[4:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            t1_tod_reg  <= tod_ms;
            t1_secs_reg <= t1_secs_next;
        end
        if (vld_reg[0])
        begin
            t2_msec_reg <= t2_msec_next;
            t2_secs_reg <= t1_secs_reg;
            t2_hour_reg <= t2_hour_next;
        end
        if (vld_reg[1])
        begin
            t3_msec_reg <= t2_msec_reg;
            t3_hour_reg <= t2_hour_reg;
            t3_sih_reg  <= t3_sih_next;
        end
        if (vld_reg[2])
        begin
            t4_msec_reg <= t3_msec_reg;
            t4_hour_reg <= t3_hour_reg;
            t4_sih_reg  <= t3_sih_reg;
            t4_min_reg  <= t4_min_next;
        end
        if (vld_reg[3])
        begin
            t5_msec_reg <= t4_msec_reg;
            t5_hour_reg <= t4_hour_reg;
            t5_min_reg  <= t4_min_reg;
            t5_som_reg  <= t5_som_next;
        end
        if (vld_reg[4])
        begin
            t6_hour_reg <= t5_hour_reg;
            t6_min_reg  <= t5_min_reg;
            t6_sms_reg  <= t6_sms_next;
        end
        if (vld_reg[5])
        begin
            hour_reg   <= t6_hour_reg;
            minute_reg <= t6_min_reg;
            sms_reg    <= t6_sms_reg;
        end
    end

    assign hour          = hour_reg;
    assign minute        = minute_reg;
    assign second_millis = sms_reg;

    ap_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[5] |=> (hour < 5'd24 && minute < 6'd60 && second_millis < 16'd60000))
        else $error("time of day field out of range");

endmodule

`default_nettype wire

// ----- design/jdct_date.sv -----
// Date pipeline: Gregorian correction and day-to-date conversion.
// Depends on jdct_pkg; fixed latency of seven register stages.
`timescale 1ns / 1ps
`default_nettype none

module jdct_date
    import jdct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  day_num_t           day_num,
    output logic               out_valid,
    output logic [MONTH_W-1:0] month,
    output logic [DOM_W-1:0]   day_of_month,
    output logic [YEAR_W-1:0]  year
);

    logic [6:0]              vld_reg;

    // stage 1: century correction term
    logic [ALPHA_NUM_W-1:0]  alpha_num;
    logic [ALPHA_PROD_W-1:0] alpha_prod;
    day_num_t                d1_day_reg;
    logic [ALPHA_W-1:0]      d1_alpha_reg;
    logic [ALPHA_W-1:0]      d1_alpha_next;
    logic                    d1_greg_reg;
    logic                    d1_greg_next;

    // stage 2: shifted day count
    day_num_t                greg_day;
    day_num_t                d2_bp_reg;
    day_num_t                d2_bp_next;

    // stage 3: four-year cycles
    logic [Q1_PROD_W-1:0]    q1_prod;
    day_num_t                d3_bp_reg;
    logic [Q1_W-1:0]         d3_q1_reg;
    logic [Q1_W-1:0]         d3_q1_next;

    // stage 4: days left in the cycle
    day_num_t                q1_days;
    day_num_t                d4_bp_reg;
    logic [Q1_W-1:0]         d4_q1_reg;
    logic [R1_W-1:0]         d4_r1_reg;
    logic [R1_W-1:0]         d4_r1_next;

    // stage 5: year count
    logic [R1_W+1:0]         cyc_num;
    logic [2:0]              cyc_years;
    day_num_t                d5_b_reg;
    day_num_t                d5_b_next;
    logic [C_W-1:0]          d5_c_reg;
    logic [C_W-1:0]          d5_c_next;

    // stage 6: days into the March-based year
    logic [CD_W-1:0]         c_days;
    logic [C_W-1:0]          d6_c_reg;
    logic [REM_W-1:0]        d6_rem_reg;
    logic [REM_W-1:0]        d6_rem_next;

    // stage 7: month, day and year
    logic [E_MAX+1:1]        e_ge;
    logic [E_W-1:0]          e_idx;
    logic [MONTH_W-1:0]      mon_raw;
    logic [MONTH_W-1:0]      month_next;
    logic [DOM_W-1:0]        dom_next;
    logic signed [YR_CALC_W-1:0] yr_calc;
    logic [YEAR_W-1:0]       year_next;
    logic [MONTH_W-1:0]      month_reg;
    logic [DOM_W-1:0]        dom_reg;
    logic [YEAR_W-1:0]       year_reg;

    assign alpha_num     = ALPHA_NUM_W'({day_num, 2'b00} - ALPHA_OFS);
    assign alpha_prod    = ALPHA_PROD_W'(alpha_num) * ALPHA_PROD_W'(ALPHA_RECIP);
    assign d1_alpha_next = alpha_prod[ALPHA_SH +: ALPHA_W];
    assign d1_greg_next  = (day_num >= GREG_START);

    assign greg_day   = d1_day_reg + DAY_W'(1) + DAY_W'(d1_alpha_reg)
                      - DAY_W'(d1_alpha_reg >> 2);
    assign d2_bp_next = (d1_greg_reg ? greg_day : d1_day_reg) + (B_OFS - B_BACK);

    assign q1_prod    = Q1_PROD_W'(d2_bp_reg) * Q1_PROD_W'(Q1_RECIP);
    assign d3_q1_next = q1_prod[Q1_SH +: Q1_W];

    assign q1_days    = DAY_W'(d3_q1_reg) * DAY_W'(CYCLE_DAYS);
    assign d4_r1_next = R1_W'(d3_bp_reg - q1_days);

    // Whole years left in the cycle: floor((4*r1 + 3) / 1461), 0 to 3
    assign cyc_num = {d4_r1_reg, 2'b11};
    always_comb
    begin
        cyc_years = '0;
        for (int k = 1; k <= 4; k++)
        begin
            if (cyc_num >= (R1_W+2)'(k * CYCLE_DAYS))
                cyc_years = cyc_years + 3'd1;
        end
    end
    assign d5_c_next = C_W'({d4_q1_reg, 2'b00}) + C_W'(cyc_years);
    assign d5_b_next = d4_bp_reg + B_BACK;

    assign c_days      = CD_W'(d5_c_reg) * CD_W'(DAYS_PER_YEAR) + CD_W'(d5_c_reg >> 2);
    assign d6_rem_next = REM_W'(CD_W'(d5_b_reg) - c_days);

    // Month index from the thermometer of threshold compares
    always_comb
    begin
        e_ge[E_MAX+1] = 1'b0;
        for (int k = 1; k <= E_MAX; k++)
            e_ge[k] = (d6_rem_reg >= E_THRESH[k]);
        e_idx = '0;
        for (int k = 1; k <= E_MAX; k++)
        begin
            if (e_ge[k] && !e_ge[k+1])
                e_idx = e_idx | E_W'(k);
        end
    end

    always_comb
    begin
        dom_next = DOM_W'(d6_rem_reg - E_DAYS[e_idx]);
        mon_raw  = e_idx - MONTH_W'(1);
        if (mon_raw > MONTHS_PER_YEAR)
            month_next = mon_raw - MONTHS_PER_YEAR;
        else
            month_next = mon_raw;
        yr_calc = $signed({2'b00, d6_c_reg}) - $signed(YR_CALC_W'(YEAR_EPOCH));
        if (month_next > FEBRUARY)
            yr_calc = yr_calc - YR_CALC_W'(1);
        // no year zero
        if (yr_calc <= 0)
            yr_calc = yr_calc - YR_CALC_W'(1);
        year_next = YEAR_W'(yr_calc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[5:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            d1_day_reg   <= day_num;
            d1_alpha_reg <= d1_alpha_next;
            d1_greg_reg  <= d1_greg_next;
        end
        if (vld_reg[0])
            d2_bp_reg <= d2_bp_next;
        if (vld_reg[1])
        begin
            d3_bp_reg <= d2_bp_reg;
            d3_q1_reg <= d3_q1_next;
        end
        if (vld_reg[2])
        begin
            d4_bp_reg <= d3_bp_reg;
            d4_q1_reg <= d3_q1_reg;
            d4_r1_reg <= d4_r1_next;
        end
        if (vld_reg[3])
        begin
            d5_b_reg <= d5_b_next;
            d5_c_reg <= d5_c_next;
        end
        if (vld_reg[4])
        begin
            d6_c_reg   <= d5_c_reg;
            d6_rem_reg <= d6_rem_next;
        end
        if (vld_reg[5])
        begin
            month_reg <= month_next;
            dom_reg   <= dom_next;
            year_reg  <= year_next;
        end
    end

    assign out_valid    = vld_reg[6];
    assign month        = month_reg;
    assign day_of_month = dom_reg;
    assign year         = year_reg;

    ap_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[5] |-> (d6_rem_reg >= REM_MIN && d6_rem_reg <= REM_MAX))
        else $error("day remainder outside the March-based year");

    ap_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month != '0 && month <= MONTHS_PER_YEAR && day_of_month != '0))
        else $error("calendar date field out of range");

endmodule

`default_nettype wire

// ----- design/julian_day_to_calendar_time.sv -----
// Julian day number and millisecond-of-day to calendar date and time of day.
// done pulses once the transaction has passed the day split and the date pipeline.
// Throughput: one transaction per cycle; busy stays low, no back-pressure.
// Quotients come from reciprocal multiplies, each held in its own stage, or from threshold compares.
// Reset clears the stage valid bits only; no result is issued after reset.
// Depends on jdct_pkg, jdct_day_split, jdct_time and jdct_date.
`timescale 1ns / 1ps
`default_nettype none

module julian_day_to_calendar_time
    import jdct_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [JDAY_W-1:0]   julian_day,
    input  logic [MS_W-1:0]     millis_of_day,
    output logic                done,
    output logic [MONTH_W-1:0]  month,
    output logic [DOM_W-1:0]    day_of_month,
    output logic signed [YEAR_W-1:0] year,
    output logic [HOUR_W-1:0]   hour,
    output logic [MINUTE_W-1:0] minute,
    output logic [SMS_W-1:0]    second_millis
);

    logic              accept;
    logic              split_valid;
    day_num_t          split_day;
    tod_ms_t           split_tod;
    logic [YEAR_W-1:0] year_bits;

    // The pipeline advances every cycle, so a transaction is always taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Stages 1-2: carry whole days out of the millisecond count.
    jdct_day_split u_split (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (accept),
        .julian_day    (julian_day),
        .millis_of_day (millis_of_day),
        .out_valid     (split_valid),
        .day_num       (split_day),
        .tod_ms        (split_tod)
    );

    // Stages 3-9: date and time run side by side with equal latency,
    // so the date valid bit marks both halves of the result.
    jdct_date u_date (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (split_valid),
        .day_num      (split_day),
        .out_valid    (done),
        .month        (month),
        .day_of_month (day_of_month),
        .year         (year_bits)
    );

    jdct_time u_time (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (split_valid),
        .tod_ms        (split_tod),
        .hour          (hour),
        .minute        (minute),
        .second_millis (second_millis)
    );

    assign year = $signed(year_bits);

    // Every accepted transaction yields exactly one strobe.
    ap_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##PIPE_LATENCY done)
        else $error("result strobe missing for an accepted transaction");

    ap_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, PIPE_LATENCY))
        else $error("result strobe without an accepted transaction");

endmodule

`default_nettype wire

// ----- sim/jdct_checker.sv -----
// Checker for the Julian day to calendar time converter: predicts each transaction's date and
// time of day and compares the strobed results in order. Depends on jdct_pkg for port widths.
`timescale 1ns / 1ps

module jdct_checker
    import jdct_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [JDAY_W-1:0]        julian_day,
    input  logic [MS_W-1:0]          millis_of_day,
    input  logic                     done,
    input  logic [MONTH_W-1:0]       month,
    input  logic [DOM_W-1:0]         day_of_month,
    input  logic signed [YEAR_W-1:0] year,
    input  logic [HOUR_W-1:0]        hour,
    input  logic [MINUTE_W-1:0]      minute,
    input  logic [SMS_W-1:0]         second_millis,
    output int                       mismatches,
    output int                       outstanding
);

    localparam longint DAY_MSEC      = 86400000;
    localparam longint REFORM_JDAY   = 2299161;
    localparam longint ALPHA_BASE    = 1867216;
    localparam longint FOUR_CENTURY  = 146097;
    localparam longint B_SHIFT       = 1524;
    localparam longint YEAR_NUM_OFS  = 2442;
    localparam longint YEAR_DIV      = 7305;
    localparam longint MONTH_SCALE   = 10000;
    localparam longint MONTH_DIV     = 306001;
    localparam longint YEAR_OFFSET   = 4715;
    localparam longint SEC_PER_HOUR  = 3600;

    typedef struct {
        logic [MONTH_W-1:0]       month;
        logic [DOM_W-1:0]         day_of_month;
        logic signed [YEAR_W-1:0] year;
        logic [HOUR_W-1:0]        hour;
        logic [MINUTE_W-1:0]      minute;
        logic [SMS_W-1:0]         second_millis;
    } calendar_time_t;

    calendar_time_t pending_dates[$];
    int fail_total = 0;
    int pending_count = 0;

    assign mismatches  = fail_total;
    assign outstanding = pending_count;

    function automatic calendar_time_t to_calendar_time(input logic [JDAY_W-1:0] jd_in,
                                                        input logic [MS_W-1:0] ms_in);
        longint day;
        longint tod;
        longint alpha;
        longint a;
        longint b;
        longint c;
        longint rem;
        longint e;
        longint dom;
        longint mon;
        longint yr;
        longint secs;
        longint hr;
        longint mn;
        longint sms;
        calendar_time_t r;
        // Carry whole days out of the millisecond count
        day = longint'(jd_in) + longint'(ms_in) / DAY_MSEC;
        tod = longint'(ms_in) % DAY_MSEC;
        if (day >= REFORM_JDAY)
        begin
            alpha = (4 * (day - ALPHA_BASE) - 1) / FOUR_CENTURY;
            a = day + 1 + alpha - alpha / 4;
        end
        else
        begin
            a = day;
        end
        b   = a + B_SHIFT;
        c   = (20 * b - YEAR_NUM_OFS) / YEAR_DIV;
        rem = b - (365 * c + c / 4);
        e   = (MONTH_SCALE * rem) / MONTH_DIV;
        dom = rem - (MONTH_DIV * e) / MONTH_SCALE;
        mon = e - 1;
        if (mon > 12)
            mon -= 12;
        yr = c - YEAR_OFFSET;
        if (mon > 2)
            yr -= 1;
        // No year zero: 1 AD follows 1 BC directly
        if (yr <= 0)
            yr -= 1;
        secs = tod / 1000;
        hr   = secs / SEC_PER_HOUR;
        mn   = (secs - hr * SEC_PER_HOUR) / 60;
        sms  = tod - (hr * SEC_PER_HOUR + mn * 60) * 1000;
        r.month         = mon[MONTH_W-1:0];
        r.day_of_month  = dom[DOM_W-1:0];
        r.year          = yr[YEAR_W-1:0];
        r.hour          = hr[HOUR_W-1:0];
        r.minute        = mn[MINUTE_W-1:0];
        r.second_millis = sms[SMS_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        fail_total++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge clk)
    begin : monitor
        calendar_time_t want;
        if (rst_n)
        begin
            // Retire results before taking a new transaction; no result strobes in the cycle that accepts it
            if (done)
            begin
                if (pending_dates.size() == 0)
                begin
                    report_mismatch("result strobed with no transaction pending");
                end
                else
                begin
                    want = pending_dates.pop_front();
                    compare_field("month", int'(month), int'(want.month));
                    compare_field("day_of_month", int'(day_of_month), int'(want.day_of_month));
                    compare_field("year", int'(year), int'(want.year));
                    compare_field("hour", int'(hour), int'(want.hour));
                    compare_field("minute", int'(minute), int'(want.minute));
                    compare_field("second_millis", int'(second_millis),
                                  int'(want.second_millis));
                end
            end
            if (start && !busy)
                pending_dates.push_back(to_calendar_time(julian_day, millis_of_day));
            pending_count = pending_dates.size();
        end
    end

endmodule

// ----- sim/julian_day_to_calendar_time_tb.sv -----
// Testbench top for julian_day_to_calendar_time: drives directed and random timestamps with
// random idle gaps and gives the verdict. Depends on jdct_pkg, jdct_checker and the block.
`timescale 1ns / 1ps

module julian_day_to_calendar_time_tb
    import jdct_pkg::*;
;

    localparam int     RANDOM_ITEMS = 600;
    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     DRAIN_CYCLES = PIPE_LATENCY + 4;
    localparam logic [31:0] DAY_MSEC   = 32'd86400000;
    localparam logic [29:0] REFORM_DAY = 30'd2299161;
    localparam logic [29:0] AD_ONE_DAY = 30'd1721424;   // 1 January 1 AD

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [JDAY_W-1:0]        julian_day;
    logic [MS_W-1:0]          millis_of_day;
    logic                     done;
    logic [MONTH_W-1:0]       month;
    logic [DOM_W-1:0]         day_of_month;
    logic signed [YEAR_W-1:0] year;
    logic [HOUR_W-1:0]        hour;
    logic [MINUTE_W-1:0]      minute;
    logic [SMS_W-1:0]         second_millis;

    int mismatches;
    int outstanding;
    int cycle_count;
    int max_gap;

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    julian_day_to_calendar_time u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .julian_day    (julian_day),
        .millis_of_day (millis_of_day),
        .done          (done),
        .month         (month),
        .day_of_month  (day_of_month),
        .year          (year),
        .hour          (hour),
        .minute        (minute),
        .second_millis (second_millis)
    );

    jdct_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .julian_day    (julian_day),
        .millis_of_day (millis_of_day),
        .done          (done),
        .month         (month),
        .day_of_month  (day_of_month),
        .year          (year),
        .hour          (hour),
        .minute        (minute),
        .second_millis (second_millis),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Offer one timestamp and hold it until the block takes the transaction.
    // Enter and leave just after a falling edge, so each step sees one assignment to start.
    task automatic send_timestamp(input logic [JDAY_W-1:0] jd, input logic [MS_W-1:0] ms);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start         <= 1'b1;
        julian_day    <= jd;
        millis_of_day <= ms;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Drop start and hold off until every pending transaction has returned its result
    task automatic wait_for_drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    // Abort a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [JDAY_W-1:0] jd;
        logic [MS_W-1:0]   ms;
        logic [31:0]       k;
        rst_n         <= 1'b0;
        start         <= 1'b0;
        julian_day    <= '0;
        millis_of_day <= '0;
        max_gap       = 4;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: day zero, field extremes and the day carry
        send_timestamp(30'd0, 32'd0);
        send_timestamp(30'h3FFF_FFFF, 32'hFFFF_FFFF);
        send_timestamp(30'h3FFF_FFFF, 32'd0);
        send_timestamp(30'd0, 32'hFFFF_FFFF);
        send_timestamp(30'd0, DAY_MSEC - 32'd1);
        send_timestamp(30'd0, DAY_MSEC);
        // Directed: the Gregorian reform, directly and through the carry
        send_timestamp(REFORM_DAY - 30'd1, 32'd0);
        send_timestamp(REFORM_DAY, 32'd0);
        send_timestamp(REFORM_DAY - 30'd1, DAY_MSEC - 32'd1);
        send_timestamp(REFORM_DAY - 30'd1, DAY_MSEC);
        // Directed: around the missing year zero
        send_timestamp(AD_ONE_DAY - 30'd1, 32'd0);
        send_timestamp(AD_ONE_DAY, 32'd0);
        send_timestamp(AD_ONE_DAY - 30'd366, 32'd0);
        send_timestamp(AD_ONE_DAY - 30'd367, 32'd0);
        // Directed: leap and common February, year end
        send_timestamp(30'd2451604, 32'd0);
        send_timestamp(30'd2451605, 32'd0);
        send_timestamp(30'd2415079, 32'd0);
        send_timestamp(30'd2415080, 32'd0);
        send_timestamp(30'd2451544, DAY_MSEC - 32'd1);
        // Directed: time of day around minute and hour edges, and one mid-day value
        send_timestamp(30'd2451545, 32'd59999);
        send_timestamp(30'd2451545, 32'd60000);
        send_timestamp(30'd2451545, 32'd3599999);
        send_timestamp(30'd2451545, 32'd3600000);
        send_timestamp(30'd2451545, 32'd45296789);

        // Random: mix of realistic dates, full-range values and calendar edges
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Switch at random between back-to-back bursts and gapped stretches
            if (i % 40 == 0)
                max_gap = ($urandom_range(0, 2) == 0) ? 0 : 4;
            case ($urandom_range(0, 5))
                0:
                begin
                    jd = JDAY_W'($urandom_range(2200000, 2600000));
                    ms = $urandom_range(0, 86399999);
                end
                1:
                begin
                    jd = JDAY_W'($urandom());
                    ms = $urandom();
                end
                2:
                begin
                    jd = REFORM_DAY - 30'd4 + 30'($urandom_range(0, 8));
                    k  = $urandom_range(0, 2);
                    ms = DAY_MSEC * k + 32'($urandom_range(0, 3));
                end
                3:
                begin
                    jd = AD_ONE_DAY - 30'd800 + 30'($urandom_range(0, 1600));
                    ms = $urandom_range(0, 86399999);
                end
                4:
                begin
                    jd = JDAY_W'($urandom_range(0, 3000000));
                    ms = $urandom();
                end
                default:
                begin
                    // Land on the edge of a carried day
                    jd = ($urandom_range(0, 1) == 0) ? JDAY_W'($urandom_range(0, 400))
                                                     : JDAY_W'($urandom());
                    k  = $urandom_range(1, 49);
                    ms = ($urandom_range(0, 1) == 0) ? DAY_MSEC * k - 32'd1 : DAY_MSEC * k;
                end
            endcase
            send_timestamp(jd, ms);
            // Let the pipeline run dry now and then
            if (i % 150 == 75)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
design/jdct_pkg.sv
design/jdct_day_split.sv
design/jdct_time.sv
design/jdct_date.sv
design/julian_day_to_calendar_time.sv
sim/jdct_checker.sv
sim/julian_day_to_calendar_time_tb.sv
